FILE: src/assert_macros.svh
// Assertion macros shared by the line detector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset.
`define CLD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence on the same edge.
`define CLD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define CLD_ASSERT(label, clk, rst_n, prop, msg)
`define CLD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: src/cld_pkg.sv
// Types and constants of the calibrated line detector.
package cld_pkg;

    localparam int CHANNELS    = 4;
    localparam int SAMPLE_BITS = 10;

    localparam int GAP_W     = 9;
    localparam int WINDOW_W  = 16;
    localparam int ELAPSED_W = 16;
    localparam int THRESH_W  = 16;
    localparam int CHAN_W    = 2;
    localparam int VALUE_W   = 10;
    localparam int STATUS_W  = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam int FLAG_SLOTS = 4;
    localparam int SWITCH_BIT = 4;

    typedef logic [SAMPLE_BITS-1:0] sample_t;

    localparam sample_t FULL_SCALE = {SAMPLE_BITS{1'b1}};

    localparam logic [GAP_W-1:0]     GAP_RESET    = GAP_W'(10);
    localparam logic [WINDOW_W-1:0]  WINDOW_RESET = WINDOW_W'(5000);
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX  = {ELAPSED_W{1'b1}};
    localparam logic [STATUS_W-1:0]  STATUS_FIXED = 8'h60;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS_GAP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_WINDOW_MS  = 1'b1;

    // Item kinds carried on tuser
    localparam logic FUNC_TICK   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    typedef struct packed {
        logic               func;
        logic [CHAN_W-1:0]  channel;
        logic [VALUE_W-1:0] sample_value;
        logic               calibrate_pressed;
        logic               switch_pressed;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status_byte;
        logic                calibrating;
    } result_t;

endpackage

FILE: src/cld_core.sv
// Calibration and Schmitt decision state, updated once per stepped item.
`include "assert_macros.svh"

module cld_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  cld_pkg::item_t                item,
    input  logic [cld_pkg::GAP_W-1:0]     cfg_gap,
    input  logic [cld_pkg::WINDOW_W-1:0]  cfg_window,
    output cld_pkg::result_t              result
);

    cld_pkg::sample_t latest_reg  [cld_pkg::CHANNELS];
    cld_pkg::sample_t latest_next [cld_pkg::CHANNELS];
    cld_pkg::sample_t max_reg     [cld_pkg::CHANNELS];
    cld_pkg::sample_t max_next    [cld_pkg::CHANNELS];
    cld_pkg::sample_t min_reg     [cld_pkg::CHANNELS];
    cld_pkg::sample_t min_next    [cld_pkg::CHANNELS];

    logic [cld_pkg::CHANNELS-1:0]  flag_reg, flag_next;
    logic                          window_reg, window_next;
    logic [cld_pkg::ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic [cld_pkg::STATUS_W-1:0]  held_reg, held_next;

    cld_pkg::sample_t                           sample_in;
    logic [cld_pkg::ELAPSED_W-1:0]              elapsed_tick;
    logic [cld_pkg::SAMPLE_BITS:0]              mid_sum  [cld_pkg::CHANNELS];
    cld_pkg::sample_t                           mid      [cld_pkg::CHANNELS];
    logic [cld_pkg::THRESH_W-1:0]               up       [cld_pkg::CHANNELS];
    logic [cld_pkg::THRESH_W-1:0]               down     [cld_pkg::CHANNELS];
    logic [cld_pkg::THRESH_W-1:0]               smp_wide [cld_pkg::CHANNELS];
    logic [cld_pkg::FLAG_SLOTS+cld_pkg::CHANNELS-1:0] flag_pad;

    assign sample_in = cld_pkg::SAMPLE_BITS'(item.sample_value) & cld_pkg::FULL_SCALE;

    // Latest sample per channel, then the tick count
    always_comb begin
        for (int c = 0; c < cld_pkg::CHANNELS; c++) begin
            latest_next[c] = latest_reg[c];
            if (item.func == cld_pkg::FUNC_SAMPLE && int'(item.channel) == c) begin
                latest_next[c] = sample_in;
            end
        end
        elapsed_tick = elapsed_reg;
        if (item.func == cld_pkg::FUNC_TICK && window_reg && elapsed_reg != cld_pkg::ELAPSED_MAX) begin
            elapsed_tick = elapsed_reg + 1'b1;
        end
    end

    // Thresholds around the calibrated midpoint, 16-bit wrap
    always_comb begin
        for (int c = 0; c < cld_pkg::CHANNELS; c++) begin
            mid_sum[c]  = {1'b0, max_reg[c]} + {1'b0, min_reg[c]};
            mid[c]      = mid_sum[c][cld_pkg::SAMPLE_BITS:1];
            up[c]       = cld_pkg::THRESH_W'(mid[c]) + cld_pkg::THRESH_W'(cfg_gap);
            down[c]     = cld_pkg::THRESH_W'(mid[c]) - cld_pkg::THRESH_W'(cfg_gap);
            smp_wide[c] = cld_pkg::THRESH_W'(latest_next[c]);
        end
    end

    // Decision step: open, close, track, or decide
    always_comb begin
        window_next  = window_reg;
        elapsed_next = elapsed_tick;
        flag_next    = flag_reg;
        held_next    = held_reg;
        flag_pad     = '0;
        for (int c = 0; c < cld_pkg::CHANNELS; c++) begin
            max_next[c] = max_reg[c];
            min_next[c] = min_reg[c];
        end
        if (!window_reg && item.calibrate_pressed) begin
            window_next  = 1'b1;
            elapsed_next = '0;
            for (int c = 0; c < cld_pkg::CHANNELS; c++) begin
                max_next[c] = '0;
                min_next[c] = cld_pkg::FULL_SCALE;
            end
        end else if (window_reg && elapsed_tick > cfg_window) begin
            window_next = 1'b0;
        end else if (window_reg) begin
            for (int c = 0; c < cld_pkg::CHANNELS; c++) begin
                if (latest_next[c] > max_reg[c]) begin
                    max_next[c] = latest_next[c];
                end
                if (latest_next[c] < min_reg[c]) begin
                    min_next[c] = latest_next[c];
                end
            end
        end else begin
            for (int c = 0; c < cld_pkg::CHANNELS; c++) begin
                if (smp_wide[c] > up[c]) begin
                    flag_next[c] = 1'b0;
                end else if (smp_wide[c] < down[c]) begin
                    flag_next[c] = 1'b1;
                end
            end
            flag_pad  = {{cld_pkg::FLAG_SLOTS{1'b0}}, flag_next};
            held_next = cld_pkg::STATUS_FIXED;
            held_next[cld_pkg::FLAG_SLOTS-1:0] = flag_pad[cld_pkg::FLAG_SLOTS-1:0];
            held_next[cld_pkg::SWITCH_BIT]     = item.switch_pressed;
        end
    end

    assign result.status_byte = held_next;
    assign result.calibrating = window_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < cld_pkg::CHANNELS; c++) begin
                latest_reg[c] <= '0;
                max_reg[c]    <= cld_pkg::FULL_SCALE;
                min_reg[c]    <= '0;
            end
            flag_reg    <= '0;
            window_reg  <= 1'b0;
            elapsed_reg <= '0;
            held_reg    <= '0;
        end else if (step) begin
            for (int c = 0; c < cld_pkg::CHANNELS; c++) begin
                latest_reg[c] <= latest_next[c];
                max_reg[c]    <= max_next[c];
                min_reg[c]    <= min_next[c];
            end
            flag_reg    <= flag_next;
            window_reg  <= window_next;
            elapsed_reg <= elapsed_next;
            held_reg    <= held_next;
        end
    end

    `CLD_ASSERT_IMP(a_open_clears_elapsed, aclk, aresetn, $rose(window_reg), elapsed_reg == '0, "window opened with nonzero elapsed time")
    `CLD_ASSERT_IMP(a_close_past_window, aclk, aresetn, $fell(window_reg), elapsed_reg > $past(cfg_window), "window closed before its length ran out")
    `CLD_ASSERT_IMP(a_flags_frozen_in_window, aclk, aresetn, window_reg, $stable(flag_reg), "line flags changed during calibration")

endmodule

FILE: src/calibrated_line_detector_top.sv
// Top level of the calibrated line detector: stream handshake and config registers.
//
// Use: every input beat is either a millisecond tick (s_tuser = 0) or a
// reflectance sample for one channel (s_tuser = 1). Each accepted beat
// yields exactly one result beat on the m_ side carrying the status byte
// (line flags of channels 0-3, switch, two fixed ones) and the calibrating
// flag. Holding the calibrate button while calibration is closed opens a
// window that tracks per-channel min/max until the elapsed millisecond
// count exceeds calibration_window_ms; after that every beat, tick or
// sample, with calibrate released runs a Schmitt decision around the
// midpoint +/- hysteresis_gap. A beat passes the input register and then
// the result register before m_tvalid shows it; a low m_tready can stall
// it between them. Throughput: one beat per cycle while m_tready is high; the state
// update and decision sit in the single logic stage between the two registers.
// Stall: when m_tready is low the result register holds its beat, the
// input register keeps the next beat, and s_tready drops only once both
// are full. Reset (aresetn low, synchronous) empties both registers,
// restores gap 10 and window 5000, clears min/latest/flags/status and
// sets every maximum to full scale. Write cfg_* only while idle; cfg_ready
// is always high.
`include "assert_macros.svh"

module calibrated_line_detector_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,  // channel[1:0], sample_value[11:2],
                                                      // calibrate_pressed[12],
                                                      // switch_pressed[13], zero[15:14]
    input  logic                            s_tuser,  // func[0]
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata,  // status_byte[7:0], calibrating[8],
                                                      // zero[15:9]
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cld_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cld_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic                          in_valid_reg, in_valid_next;
    cld_pkg::item_t                in_item_reg;
    logic                          out_valid_reg, out_valid_next;
    cld_pkg::result_t              out_result_reg;
    logic [cld_pkg::GAP_W-1:0]     gap_reg;
    logic [cld_pkg::WINDOW_W-1:0]  window_reg;

    cld_pkg::item_t                s_item;
    cld_pkg::result_t              core_result;
    logic                          s_accept;
    logic                          advance;

    // Unpack the input beat
    assign s_item.func              = s_tuser;
    assign s_item.channel           = s_tdata[1:0];
    assign s_item.sample_value      = s_tdata[11:2];
    assign s_item.calibrate_pressed = s_tdata[12];
    assign s_item.switch_pressed    = s_tdata[13];

    // Advance the held beat whenever the result register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers load on their handshake only
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg <= s_item;
        end
        if (advance) begin
            out_result_reg <= core_result;
        end
    end

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_reg    <= cld_pkg::GAP_RESET;
            window_reg <= cld_pkg::WINDOW_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                cld_pkg::REG_HYSTERESIS_GAP: gap_reg    <= cfg_data[cld_pkg::GAP_W-1:0];
                cld_pkg::REG_CAL_WINDOW_MS:  window_reg <= cfg_data[cld_pkg::WINDOW_W-1:0];
                default: ;
            endcase
        end
    end

    cld_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .item       (in_item_reg),
        .cfg_gap    (gap_reg),
        .cfg_window (window_reg),
        .result     (core_result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_result_reg.calibrating, out_result_reg.status_byte};

    `CLD_ASSERT_IMP(a_status_top_bit_zero, aclk, aresetn, m_tvalid, m_tdata[7] == 1'b0, "status bit 7 set")
    `CLD_ASSERT_IMP(a_status_fixed_bits, aclk, aresetn, m_tvalid, (m_tdata[7:0] == 8'h00) || (m_tdata[6:5] == 2'b11), "status fixed bits wrong")
    `CLD_ASSERT(a_held_beat_kept, aclk, aresetn, (in_valid_reg && !advance) |=> in_valid_reg, "held input beat dropped")

endmodule

FILE: dv/testbench.sv
// Self-checking testbench of the calibrated line detector top level.
`timescale 1ns / 100ps

module testbench;

    localparam int CYCLE_LIMIT = 60000;
    localparam int DRAIN_CYCLES = 10;

    // Scoreboard: tracks calibration and Schmitt state, queues the expected status beats.
    class status_scoreboard;
        logic [cld_pkg::GAP_W-1:0]     gap;
        logic [cld_pkg::WINDOW_W-1:0]  window_ms;
        cld_pkg::sample_t              latest [cld_pkg::CHANNELS];
        cld_pkg::sample_t              vmax [cld_pkg::CHANNELS];
        cld_pkg::sample_t              vmin [cld_pkg::CHANNELS];
        bit                            flag [cld_pkg::CHANNELS];
        bit                            window_open;
        logic [cld_pkg::ELAPSED_W-1:0] elapsed;
        logic [cld_pkg::STATUS_W-1:0]  status;
        cld_pkg::result_t              expected_status [$];
        int                            mismatches;
        int                            compared;
        int                            ticks;
        int                            samples;
        int                            windows;

        function new();
            gap = cld_pkg::GAP_RESET;
            window_ms = cld_pkg::WINDOW_RESET;
            for (int c = 0; c < cld_pkg::CHANNELS; c++) begin
                latest[c] = '0;
                vmax[c] = cld_pkg::FULL_SCALE;
                vmin[c] = '0;
                flag[c] = 1'b0;
            end
            window_open = 1'b0;
            elapsed = '0;
            status = '0;
        endfunction

        function void set_reg(logic [cld_pkg::CFG_IDX_W-1:0] idx,
                              logic [cld_pkg::CFG_DATA_W-1:0] val);
            if (idx == cld_pkg::REG_HYSTERESIS_GAP)
                gap = val[cld_pkg::GAP_W-1:0];
            else if (idx == cld_pkg::REG_CAL_WINDOW_MS)
                window_ms = val[cld_pkg::WINDOW_W-1:0];
        endfunction

        function int midpoint(int c);
            logic [cld_pkg::THRESH_W-1:0] m;
            m = (cld_pkg::THRESH_W'(vmax[c]) + cld_pkg::THRESH_W'(vmin[c])) >> 1;
            return int'(m);
        endfunction

        function int pending();
            return expected_status.size();
        endfunction

        // Apply one accepted beat and queue the status it must produce.
        function void predict_beat(cld_pkg::item_t it);
            logic [cld_pkg::THRESH_W-1:0] mid;
            logic [cld_pkg::THRESH_W-1:0] up;
            logic [cld_pkg::THRESH_W-1:0] down;
            logic [cld_pkg::STATUS_W-1:0] st;
            cld_pkg::result_t             r;
            if (it.func == cld_pkg::FUNC_SAMPLE) begin
                samples++;
                if (int'(it.channel) < cld_pkg::CHANNELS)
                    latest[it.channel] = it.sample_value;
            end else begin
                ticks++;
                if (window_open && elapsed != cld_pkg::ELAPSED_MAX)
                    elapsed = elapsed + 1'b1;
            end

            if (!window_open && it.calibrate_pressed) begin
                windows++;
                window_open = 1'b1;
                elapsed = '0;
                for (int c = 0; c < cld_pkg::CHANNELS; c++) begin
                    vmax[c] = '0;
                    vmin[c] = cld_pkg::FULL_SCALE;
                end
            end else if (window_open && elapsed > window_ms) begin
                window_open = 1'b0;
            end else if (window_open) begin
                for (int c = 0; c < cld_pkg::CHANNELS; c++) begin
                    if (latest[c] > vmax[c])
                        vmax[c] = latest[c];
                    if (latest[c] < vmin[c])
                        vmin[c] = latest[c];
                end
            end else begin
                st = cld_pkg::STATUS_FIXED;
                for (int c = 0; c < cld_pkg::CHANNELS; c++) begin
                    mid = cld_pkg::THRESH_W'(midpoint(c));
                    // both thresholds wrap at 16 bits
                    up = mid + cld_pkg::THRESH_W'(gap);
                    down = mid - cld_pkg::THRESH_W'(gap);
                    if (cld_pkg::THRESH_W'(latest[c]) > up)
                        flag[c] = 1'b0;
                    else if (cld_pkg::THRESH_W'(latest[c]) < down)
                        flag[c] = 1'b1;
                    if (c < cld_pkg::FLAG_SLOTS && flag[c])
                        st[c] = 1'b1;
                end
                if (it.switch_pressed)
                    st[cld_pkg::SWITCH_BIT] = 1'b1;
                status = st;
            end

            r.status_byte = status;
            r.calibrating = window_open;
            expected_status.push_back(r);
        endfunction

        // Compare one result beat against the oldest queued status.
        function void check_status(logic [15:0] data);
            cld_pkg::result_t exp_r;
            if (expected_status.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result beat %04h arrived with nothing pending", data);
                return;
            end
            exp_r = expected_status.pop_front();
            compared++;
            if (data[7:0] !== exp_r.status_byte || data[8] !== exp_r.calibrating) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("beat %0d: status_byte exp %02h got %02h, calibrating exp %0d got %0d",
                             compared, exp_r.status_byte, data[7:0], exp_r.calibrating, data[8]);
            end
        endfunction
    endclass

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [15:0]                    s_tdata = '0;
    logic                           s_tuser = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [15:0]                    m_tdata;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [cld_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [cld_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    status_scoreboard sb = new();

    int send_idle = 0;       // percent of cycles the sender holds off
    int recv_idle = 0;       // percent of cycles the receiver stalls
    int quiet_left = 0;      // beats left in a stretch with no idling at all
    int settings_used = 0;
    int cycle_count = 0;

    calibrated_line_detector_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Bound the run: a hung handshake must not spin forever.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count, sb.pending());
            $display("testbench failed");
            $finish;
        end
    end

    // Receiver: stall at random on the falling edge, check on the rising edge.
    always @(negedge aclk) begin
        m_tready <= (quiet_left > 0) || ($urandom_range(99) >= recv_idle);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_status(m_tdata);
    end

    // Drive one input beat; enter and leave at a falling edge.
    task automatic beat(logic func, logic [cld_pkg::CHAN_W-1:0] ch,
                        logic [cld_pkg::VALUE_W-1:0] val, logic cal, logic sw);
        cld_pkg::item_t it;
        it.func = func;
        it.channel = ch;
        it.sample_value = val;
        it.calibrate_pressed = cal;
        it.switch_pressed = sw;
        // hold off the sender at random unless inside a quiet stretch
        while (quiet_left == 0 && $urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        if (quiet_left > 0)
            quiet_left--;
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, sw, cal, val, ch};
        s_tuser <= func;
        do @(posedge aclk); while (!s_tready);
        sb.predict_beat(it);
        @(negedge aclk);
    endtask

    // Stop sending and wait until every queued status has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (sb.pending() != 0);
    endtask

    // Write one register while the block is idle.
    task automatic write_reg(logic [cld_pkg::CFG_IDX_W-1:0] idx,
                             logic [cld_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, val);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic write_settings(logic [cld_pkg::GAP_W-1:0] g,
                                  logic [cld_pkg::WINDOW_W-1:0] w);
        drain_results();
        write_reg(cld_pkg::REG_HYSTERESIS_GAP, cld_pkg::CFG_DATA_W'(g));
        write_reg(cld_pkg::REG_CAL_WINDOW_MS, cld_pkg::CFG_DATA_W'(w));
        settings_used++;
    endtask

    // Pick a decision-phase sample: full range, an extreme, or near the thresholds.
    function automatic logic [cld_pkg::VALUE_W-1:0] decision_value(int c);
        int g;
        int v;
        g = int'(sb.gap);
        case ($urandom_range(2))
            0: v = int'($urandom_range(0, 1023));
            1: v = $urandom_range(1) ? 1023 : 0;
            default: begin
                v = sb.midpoint(c) + int'($urandom_range(0, 2 * g + 4)) - (g + 2);
            end
        endcase
        if (v < 0)
            v = 0;
        if (v > 1023)
            v = 1023;
        return cld_pkg::VALUE_W'(v);
    endfunction

    // Random traffic: mostly press / window / decision sequences, some noise.
    task automatic run_block(int n);
        int done_n;
        int len;
        int lo;
        int hi;
        int c;
        done_n = 0;
        while (done_n < n) begin
            if ($urandom_range(3) != 0) begin
                lo = int'($urandom_range(0, 1023));
                hi = lo + int'($urandom_range(0, 300));
                if (hi > 1023)
                    hi = 1023;
                if ($urandom_range(9) == 0)
                    quiet_left = 30;
                beat(1'($urandom_range(1)), cld_pkg::CHAN_W'($urandom_range(3)),
                     cld_pkg::VALUE_W'($urandom_range(lo, hi)), 1'b1,
                     1'($urandom_range(1)));
                done_n++;
                // track inside the window until enough ticks have passed
                while (sb.window_open) begin
                    beat($urandom_range(1) ? cld_pkg::FUNC_TICK : cld_pkg::FUNC_SAMPLE,
                         cld_pkg::CHAN_W'($urandom_range(3)),
                         cld_pkg::VALUE_W'($urandom_range(lo, hi)),
                         $urandom_range(7) == 0, 1'($urandom_range(1)));
                    done_n++;
                end
                if ($urandom_range(11) == 0)
                    drain_results();
                len = int'($urandom_range(5, 25));
                repeat (len) begin
                    c = int'($urandom_range(3));
                    beat($urandom_range(7) == 0 ? cld_pkg::FUNC_TICK : cld_pkg::FUNC_SAMPLE,
                         cld_pkg::CHAN_W'(c), decision_value(c), 1'b0,
                         1'($urandom_range(1)));
                end
                done_n += len;
            end else begin
                len = int'($urandom_range(1, 10));
                repeat (len) begin
                    beat(1'($urandom_range(1)), cld_pkg::CHAN_W'($urandom_range(3)),
                         cld_pkg::VALUE_W'($urandom_range(0, 1023)), $urandom_range(7) == 0,
                         1'($urandom_range(1)));
                end
                done_n += len;
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle = 25;
        recv_idle = 62;

        // Directed part under reset settings: the first press opens the window
        // before any decision, so status stays zero.
        beat(cld_pkg::FUNC_TICK, 2'd0, 10'd0, 1'b1, 1'b0);
        beat(cld_pkg::FUNC_SAMPLE, 2'd1, 10'd1023, 1'b1, 1'b0);  // press while open: ignore
        beat(cld_pkg::FUNC_SAMPLE, 2'd0, 10'd0, 1'b0, 1'b0);
        beat(cld_pkg::FUNC_SAMPLE, 2'd2, 10'd0, 1'b0, 1'b1);
        beat(cld_pkg::FUNC_SAMPLE, 2'd3, 10'd1023, 1'b0, 1'b1);
        beat(cld_pkg::FUNC_SAMPLE, 2'd2, 10'd1023, 1'b0, 1'b0);
        beat(cld_pkg::FUNC_TICK, 2'd0, 10'd0, 1'b0, 1'b0);
        beat(cld_pkg::FUNC_TICK, 2'd3, 10'd1023, 1'b0, 1'b1);
        // shrink the window while it is open, then close it with one more tick
        drain_results();
        write_reg(cld_pkg::REG_CAL_WINDOW_MS, 16'd2);
        beat(cld_pkg::FUNC_TICK, 2'd0, 10'd0, 1'b0, 1'b0);
        beat(cld_pkg::FUNC_SAMPLE, 2'd0, 10'd0, 1'b0, 1'b1);     // gap above midpoint: down wraps
        beat(cld_pkg::FUNC_TICK, 2'd1, 10'd0, 1'b0, 1'b0);       // tick while closed
        beat(cld_pkg::FUNC_SAMPLE, 2'd2, 10'd1023, 1'b0, 1'b0);
        beat(cld_pkg::FUNC_SAMPLE, 2'd2, 10'd512, 1'b0, 1'b1);
        write_settings(9'd0, 16'd2);
        beat(cld_pkg::FUNC_SAMPLE, 2'd3, 10'd0, 1'b0, 1'b0);
        beat(cld_pkg::FUNC_SAMPLE, 2'd3, 10'd1023, 1'b0, 1'b0);
        beat(cld_pkg::FUNC_SAMPLE, 2'd3, 10'd511, 1'b0, 1'b1);
        write_settings(9'd511, 16'd1);
        beat(cld_pkg::FUNC_SAMPLE, 2'd1, 10'd0, 1'b0, 1'b0);
        beat(cld_pkg::FUNC_SAMPLE, 2'd1, 10'd1023, 1'b0, 1'b1);
        beat(cld_pkg::FUNC_SAMPLE, 2'd0, 10'd700, 1'b1, 1'b1);   // reopen with the shortest window
        beat(cld_pkg::FUNC_TICK, 2'd0, 10'd0, 1'b0, 1'b0);
        beat(cld_pkg::FUNC_TICK, 2'd0, 10'd0, 1'b0, 1'b0);
        beat(cld_pkg::FUNC_SAMPLE, 2'd0, 10'd300, 1'b0, 1'b0);

        // Random part: three idle profiles, three settings each.
        for (int p = 0; p < 3; p++) begin
            send_idle = (p == 0) ? 25 : (p == 1) ? 62 : 0;
            recv_idle = (p == 0) ? 62 : (p == 1) ? 25 : 0;
            for (int b = 0; b < 3; b++) begin
                case (b)
                    0: write_settings((p == 1) ? 9'd511 : 9'd0, 16'd1);
                    1: write_settings(cld_pkg::GAP_W'($urandom_range(0, 40)),
                                      cld_pkg::WINDOW_W'($urandom_range(1, 12)));
                    default: write_settings(cld_pkg::GAP_W'($urandom_range(0, 511)),
                                            cld_pkg::WINDOW_W'($urandom_range(1, 6)));
                endcase
                run_block(180);
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("ran %0d ticks and %0d samples over %0d register settings",
                 sb.ticks, sb.samples, settings_used);
        $display("opened %0d calibration windows, compared %0d result beats, %0d mismatches",
                 sb.windows, sb.compared, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
